@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker in icq_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ICQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("icq check failed");

// next-cycle implication, disabled while reset is held
`define ICQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("icq check failed");

`endif

@@ rtl/icq_pkg.sv @@
`timescale 1ns / 1ps

package icq_pkg;

  // field widths
  localparam int HANDLE_W    = 16;
  localparam int NUM_W       = 63;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 88;

  // action codes carried in the input tuser
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_POP    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_RESET  = 2'd3
  } action_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAST_TAIL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STEPPED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RESET_BUSY = 3'd4;

  // decoded command passed from the front end to the back end
  typedef struct packed {
    action_t             action;
    logic [HANDLE_W-1:0] handle;
    logic [NUM_W-1:0]    index;
    logic [NUM_W-1:0]    index_p1;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BS_IDLE,
    BS_EVAL,
    BS_POP,
    BS_CLEAR,
    BS_CLEAR_END
  } back_state_t;

endpackage

@@ rtl/icq_front.sv @@
`timescale 1ns / 1ps

module icq_front import icq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // handle[15:0], index[78:16], zero pad
  input  logic [1:0]            in_tuser,   // action[1:0]
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  logic cmd_valid_r;
  cmd_t cmd_r;
  cmd_t cmd_dec;

  // decode the incoming item and precompute index + 1
  always_comb begin
    cmd_dec.action   = action_t'(in_tuser);
    cmd_dec.handle   = in_tdata[HANDLE_W-1:0];
    cmd_dec.index    = in_tdata[HANDLE_W +: NUM_W];
    cmd_dec.index_p1 = in_tdata[HANDLE_W +: NUM_W] + NUM_W'(1);
  end

  assign in_tready = !cmd_valid_r || cmd_ready;
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

  // pipeline register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (in_tready) begin
      cmd_valid_r <= in_tvalid;
    end
  end

  // pipeline register payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= cmd_dec;
    end
  end

endmodule

@@ rtl/icq_cmdq.sv @@
`timescale 1ns / 1ps

module icq_cmdq import icq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_cmd   = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

@@ rtl/icq_back.sv @@
`timescale 1ns / 1ps

module icq_back import icq_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  cmd_t                   cmd,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int SLOT_W = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [NUM_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [SLOT_W-1:0] hold_h_r, hold_h_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic                out_has_r, out_has_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [NUM_W-1:0]    out_first_r, out_first_nxt;
  logic                out_last_r, out_last_nxt;

  logic [SLOT_W-1:0] slot_mem [DEPTH];
  logic [SLOT_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;

  logic              out_free;
  logic              borrow;
  logic [NUM_W-1:0]  diff;
  logic              past_tail;
  logic [SUM_W-1:0]  tail_sum;
  logic [AW-1:0]     head_inc;

  assign out_free = !out_valid_r || out_tready;

  // distance from the base and range checks for pop-until
  assign {borrow, diff} = {1'b0, cmd_r.index} - {1'b0, base_r};
  assign past_tail = (|diff[NUM_W-1:CNT_W]) || (diff[CNT_W-1:0] >= count_r);

  // tail slot and next head slot, wrapping at DEPTH
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign wr_addr  = (tail_sum >= SUM_W'(DEPTH)) ? AW'(tail_sum - SUM_W'(DEPTH)) : AW'(tail_sum);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // sequencer: next state and result generation
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    base_nxt       = base_r;
    left_nxt       = left_r;
    hold_v_nxt     = hold_v_r;
    hold_h_nxt     = hold_h_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_handle_nxt = out_handle_r;
    out_has_nxt    = out_has_r;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_last_nxt   = out_last_r;
    cmd_ready      = 1'b0;
    wr_en          = 1'b0;
    rd_addr        = head_r;

    unique case (state_r)
      BS_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          state_nxt = BS_EVAL;
        end
      end

      BS_EVAL: begin
        if (out_free) begin
          // default single result, overridden per action
          out_valid_nxt  = 1'b1;
          out_handle_nxt = '0;
          out_has_nxt    = 1'b0;
          out_status_nxt = ST_OK;
          out_first_nxt  = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = BS_IDLE;
          unique case (cmd_r.action)
            ACT_APPEND: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (count_r == '0 || borrow) begin
                out_first_nxt = cmd_r.index_p1;
              end else if (past_tail) begin
                out_status_nxt = ST_PAST_TAIL;
              end else begin
                out_valid_nxt = 1'b0;
                left_nxt      = diff[CNT_W-1:0];
                state_nxt     = BS_POP;
              end
            end
            ACT_CLEAR: begin
              out_valid_nxt = 1'b0;
              left_nxt      = count_r;
              hold_v_nxt    = 1'b0;
              state_nxt     = BS_CLEAR;
            end
            ACT_RESET: begin
              if (count_r != '0) begin
                out_status_nxt = ST_RESET_BUSY;
              end else begin
                base_nxt = cmd_r.index;
              end
            end
            default: ;
          endcase
        end
      end

      // one removed entry per cycle while the result channel is free, up to the requested number
      BS_POP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_handle_nxt = HANDLE_W'(rd_data_r);
          out_has_nxt    = 1'b1;
          out_status_nxt = ST_OK;
          out_first_nxt  = base_r;
          out_last_nxt   = (left_r == '0);
          head_nxt       = head_inc;
          rd_addr        = head_inc;
          count_nxt      = count_r - CNT_W'(1);
          left_nxt       = left_r - CNT_W'(1);
          if (left_r == '0) begin
            base_nxt  = cmd_r.index_p1;
            state_nxt = BS_IDLE;
          end
        end
      end

      // walk all entries, holding back one non-null handle to mark the last
      BS_CLEAR: begin
        if (left_r == '0) begin
          state_nxt = BS_CLEAR_END;
        end else if (rd_data_r == '0 || !hold_v_r || out_free) begin
          if (rd_data_r != '0) begin
            if (hold_v_r) begin
              out_valid_nxt  = 1'b1;
              out_handle_nxt = HANDLE_W'(hold_h_r);
              out_has_nxt    = 1'b1;
              out_status_nxt = ST_STEPPED;
              out_first_nxt  = '0;
              out_last_nxt   = 1'b0;
            end
            hold_v_nxt = 1'b1;
            hold_h_nxt = rd_data_r;
          end
          head_nxt = head_inc;
          rd_addr  = head_inc;
          left_nxt = left_r - CNT_W'(1);
        end
      end

      BS_CLEAR_END: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_first_nxt  = '0;
          out_last_nxt   = 1'b1;
          if (hold_v_r) begin
            out_handle_nxt = HANDLE_W'(hold_h_r);
            out_has_nxt    = 1'b1;
            out_status_nxt = ST_STEPPED;
          end else begin
            out_handle_nxt = '0;
            out_has_nxt    = 1'b0;
            out_status_nxt = ST_OK;
          end
          count_nxt  = '0;
          head_nxt   = '0;
          base_nxt   = '0;
          hold_v_nxt = 1'b0;
          state_nxt  = BS_IDLE;
        end
      end

      default: state_nxt = BS_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      base_r      <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    left_r       <= left_nxt;
    hold_h_r     <= hold_h_nxt;
    out_handle_r <= out_handle_nxt;
    out_has_r    <= out_has_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_last_r   <= out_last_nxt;
  end

  // handle store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= cmd_r.handle[SLOT_W-1:0];
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - NUM_W - STATUS_W - HANDLE_W)'(0),
                       out_first_r, out_status_r, out_handle_r};

endmodule

@@ rtl/indexed_completion_queue.sv @@
`timescale 1ns / 1ps

// Indexed completion queue: a FIFO of up to DEPTH completion handles whose
// head entry carries a running sequence number. Each input item (action in
// in_tuser) produces one or more result items, the final one flagged by
// out_tlast. An append, a base reset, or a pop that removes nothing is
// settled in the evaluation state. A pop that removes n entries yields one
// result per removed entry. A clear walks the handle store through its
// single read port, one entry per cycle unless a held handle waits on
// out_tready, and then issues its final result. Any result that waits on
// out_tready holds up the back end. An accepted item passes through the
// front register and the command queue before the back end takes it. The
// front register and the two-entry command queue let new items be taken
// while the back end is still busy or a result waits on out_tready.
module indexed_completion_queue import icq_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // handle[15:0], index[78:16], zero pad
  input  logic [1:0]             in_tuser,   // action[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_handle[15:0], status[18:16],
                                             // first_number[81:19], zero pad
  output logic                   out_tuser,  // has_entry
  output logic                   out_tlast   // last
);

  logic fr_valid;
  logic fr_ready;
  cmd_t fr_cmd;
  logic bk_valid;
  logic bk_ready;
  cmd_t bk_cmd;

  // item intake and decode
  icq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  // decoupling queue
  icq_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_cmd   (fr_cmd),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_cmd   (bk_cmd)
  );

  // queue state, handle store and result generation
  icq_back #(
    .DEPTH       (DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (bk_valid),
    .cmd_ready  (bk_ready),
    .cmd        (bk_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ rtl/icq_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module icq_checker import icq_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  logic [HANDLE_W-1:0]    chk_handle;
  logic [STATUS_W-1:0]    chk_status;
  logic [NUM_W-1:0]       chk_first;
  logic [OUT_TDATA_W+1:0] out_word;
  logic                   out_stall;
  logic                   out_stepped;
  logic                   status_ok;
  logic                   status_known;

  assign chk_handle = out_tdata[HANDLE_W-1:0];
  assign chk_status = out_tdata[HANDLE_W +: STATUS_W];
  assign chk_first  = out_tdata[HANDLE_W + STATUS_W +: NUM_W];

  // condensed views of the result channel
  assign out_word     = {out_tlast, out_tuser, out_tdata};
  assign out_stall    = out_tvalid && !out_tready;
  assign out_stepped  = out_tvalid && (chk_status == ST_STEPPED);
  assign status_ok    = (chk_status == ST_OK);
  assign status_known = (chk_status <= ST_RESET_BUSY);

  // a stalled result holds until taken
  `ICQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_word))

  // a result without an entry carries the null handle
  `ICQ_ASSERT_IMP(a_null_handle, clk, rst_n, out_tvalid && !out_tuser, chk_handle == '0)

  // stepped-down results always carry an entry
  `ICQ_ASSERT_IMP(a_stepped_entry, clk, rst_n, out_stepped, out_tuser)

  // error and stepped-down results report no sequence number
  `ICQ_ASSERT_IMP(a_status_first, clk, rst_n, out_tvalid && !status_ok, chk_first == '0)

  // only defined status codes appear
  `ICQ_ASSERT_IMP(a_status_code, clk, rst_n, out_tvalid, status_known)

endmodule

bind indexed_completion_queue icq_checker u_icq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ verif/icq_result_checker.sv @@
`timescale 1ns / 1ps

// watches both streams of the indexed completion queue, keeps a shadow copy of
// the queue, and compares every result item with the predicted one
module icq_result_checker import icq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // handle[15:0], index[78:16], zero pad
  input  logic [1:0]             in_tuser,   // action[1:0]
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // out_handle[15:0], status[18:16],
                                             // first_number[81:19], zero pad
  input  logic                   out_tuser,  // has_entry
  input  logic                   out_tlast,  // last
  output int                     mismatches,
  output int                     pending,
  output int                     results_seen,
  output logic [NUM_W-1:0]       base_now,
  output logic [6:0]             count_now
);

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                has_entry;
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    first_num;
    logic                last;
  } completion_t;

  // shadow queue state
  logic [HANDLE_W-1:0] slots [DEPTH];
  logic [5:0]          head_ptr = '0;
  logic [6:0]          occupancy = '0;
  logic [NUM_W-1:0]    base_num = '0;

  completion_t expected_q [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
    base_now     = '0;
    count_now    = '0;
  end

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("tb: %0t result %0d bad %s: got 0x%0h, expected 0x%0h",
             $time, results_seen, field, got, want);
  endtask

  task automatic push_result(logic [HANDLE_W-1:0] h, logic has, logic [STATUS_W-1:0] st,
                             logic [NUM_W-1:0] num, logic lst);
    completion_t c;
    c.handle    = h;
    c.has_entry = has;
    c.status    = st;
    c.first_num = num;
    c.last      = lst;
    expected_q.insert(expected_q.size(), c);
  endtask

  // predict the results of one accepted item and update the shadow queue
  task automatic apply_command(action_t act, logic [HANDLE_W-1:0] h, logic [NUM_W-1:0] idx);
    logic [NUM_W-1:0] span;
    logic [NUM_W-1:0] old_base;
    logic [NUM_W-1:0] next_num;
    logic [5:0]       slot_ix;
    int               n_pop;
    int               last_k;
    next_num = idx + 63'd1;
    case (act)
      ACT_APPEND: begin
        if (occupancy == 7'(DEPTH)) begin
          // full: the handle is dropped
          push_result('0, 1'b0, ST_OVERFLOW, '0, 1'b1);
        end else begin
          slot_ix = head_ptr + occupancy[5:0];
          slots[slot_ix] = h;
          occupancy++;
          push_result('0, 1'b0, ST_OK, '0, 1'b1);
        end
      end
      ACT_POP: begin
        if (occupancy == 0 || idx < base_num) begin
          // nothing to remove: report the number after the requested one
          push_result('0, 1'b0, ST_OK, next_num, 1'b1);
        end else begin
          span = idx - base_num;
          if (span >= 63'(occupancy)) begin
            push_result('0, 1'b0, ST_PAST_TAIL, '0, 1'b1);
          end else begin
            old_base = base_num;
            n_pop = int'(span[6:0]);
            for (int i = 0; i <= n_pop; i++) begin
              push_result(slots[head_ptr], 1'b1, ST_OK, old_base, i == n_pop);
              head_ptr++;
              occupancy--;
            end
            base_num = next_num;
          end
        end
      end
      ACT_CLEAR: begin
        // null handles are skipped, so find the last live one first
        last_k = -1;
        for (int k = 0; k < int'(occupancy); k++) begin
          slot_ix = head_ptr + 6'(k);
          if (slots[slot_ix] != '0) last_k = k;
        end
        if (last_k < 0) begin
          push_result('0, 1'b0, ST_OK, '0, 1'b1);
        end else begin
          for (int k = 0; k <= last_k; k++) begin
            slot_ix = head_ptr + 6'(k);
            if (slots[slot_ix] != '0) begin
              push_result(slots[slot_ix], 1'b1, ST_STEPPED, '0, k == last_k);
            end
          end
        end
        occupancy = '0;
        head_ptr  = '0;
        base_num  = '0;
      end
      default: begin
        if (occupancy != 0) begin
          push_result('0, 1'b0, ST_RESET_BUSY, '0, 1'b1);
        end else begin
          base_num = idx;
          push_result('0, 1'b0, ST_OK, '0, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_result();
    completion_t want;
    results_seen++;
    if (expected_q.size() == 0) begin
      report_mismatch("item, none expected", 64'(out_tdata[15:0]), 64'd0);
    end else begin
      want = expected_q[0];
      expected_q.delete(0);
      if (out_tdata[15:0] !== want.handle)
        report_mismatch("out_handle", 64'(out_tdata[15:0]), 64'(want.handle));
      if (out_tuser !== want.has_entry)
        report_mismatch("has_entry", 64'(out_tuser), 64'(want.has_entry));
      if (out_tdata[18:16] !== want.status)
        report_mismatch("status", 64'(out_tdata[18:16]), 64'(want.status));
      if (out_tdata[81:19] !== want.first_num)
        report_mismatch("first_number", 64'(out_tdata[81:19]), 64'(want.first_num));
      if (out_tlast !== want.last)
        report_mismatch("last", 64'(out_tlast), 64'(want.last));
    end
  endtask

  // results are compared before the new item is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        apply_command(action_t'(in_tuser), in_tdata[15:0], in_tdata[78:16]);
      end
    end
    pending   = expected_q.size();
    base_now  = base_num;
    count_now = occupancy;
  end

endmodule

@@ verif/indexed_completion_queue_test.sv @@
`timescale 1ns / 1ps

module indexed_completion_queue_test;
  import icq_pkg::*;

  localparam int QUEUE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 410;
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam logic [NUM_W-1:0] TOP_NUM = '1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  int               mismatches;
  int               pending;
  int               results_seen;
  logic [NUM_W-1:0] base_now;
  logic [6:0]       count_now;

  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int cycles = 0;
  int sent_total = 0;
  int sent_by_action [4] = '{0, 0, 0, 0};
  int fills = 0;

  indexed_completion_queue #(
    .DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(16)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  icq_result_checker #(
    .DEPTH(QUEUE_DEPTH)
  ) checker_inst (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .mismatches(mismatches),
    .pending(pending),
    .results_seen(results_seen),
    .base_now(base_now),
    .count_now(count_now)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall before each item unless running quiet
  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = rx_quiet ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(action_t act, logic [HANDLE_W-1:0] h, logic [NUM_W-1:0] idx);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, idx, h};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent_total++;
    sent_by_action[act]++;
  endtask

  function automatic logic [HANDLE_W-1:0] random_handle();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 25) return '1;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [NUM_W-1:0] random_num();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[62:0];
  endfunction

  // mostly in range, with below-base, past-tail and wild numbers mixed in
  function automatic logic [NUM_W-1:0] pop_index();
    int pick;
    pick = $urandom_range(0, 9);
    if (count_now != 0 && pick < 6)
      return base_now + 63'($urandom_range(0, int'(count_now) - 1));
    if (pick == 6) return base_now - 63'($urandom_range(1, 5));
    if (pick == 7) return base_now + 63'(count_now) + 63'($urandom_range(0, 3));
    return random_num();
  endfunction

  // new base: small, close to wrapping, or anywhere
  function automatic logic [NUM_W-1:0] base_index();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 63'($urandom_range(0, 100));
    if (pick < 7) return TOP_NUM - 63'($urandom_range(0, 40));
    return random_num();
  endfunction

  task automatic random_op();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) send_item(ACT_APPEND, random_handle(), random_num());
    else if (pick < 80) send_item(ACT_POP, random_handle(), pop_index());
    else if (pick < 88) send_item(ACT_CLEAR, random_handle(), random_num());
    else send_item(ACT_RESET, random_handle(), base_index());
  endtask

  initial begin : stimulus
    int phase;
    int random_start;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pops, base near the wrap point, all actions, every status but overflow
    tx_quiet = 1'b1;
    send_item(ACT_POP, '0, '0);
    send_item(ACT_POP, '1, TOP_NUM);
    send_item(ACT_RESET, '0, TOP_NUM - 63'd2);
    send_item(ACT_APPEND, 16'hFFFF, '0);
    send_item(ACT_APPEND, 16'h0000, TOP_NUM);
    send_item(ACT_APPEND, 16'h0001, '0);
    send_item(ACT_APPEND, 16'hA5A5, '0);
    send_item(ACT_APPEND, 16'h5A5A, '0);
    tx_quiet = 1'b0;
    send_item(ACT_POP, '0, 63'd5);
    send_item(ACT_RESET, '0, '0);
    send_item(ACT_POP, '0, TOP_NUM - 63'd1);
    send_item(ACT_POP, '0, TOP_NUM);
    send_item(ACT_POP, '0, 63'd5);
    send_item(ACT_POP, '0, '0);
    send_item(ACT_APPEND, 16'h0000, '0);
    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_CLEAR, '1, TOP_NUM);
    send_item(ACT_APPEND, 16'h0000, '0);
    send_item(ACT_APPEND, 16'h0000, '0);
    send_item(ACT_CLEAR, '0, '0);
    send_item(ACT_RESET, '0, TOP_NUM);
    send_item(ACT_RESET, '0, '0);
    send_item(ACT_POP, '0, '0);

    // random phases, two of them filling the queue to overflow
    random_start = sent_total;
    phase = 0;
    while (sent_total - random_start < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (phase == 2 || phase == 8) begin
        while (count_now != 7'(QUEUE_DEPTH)) begin
          send_item(ACT_APPEND, random_handle(), random_num());
        end
        repeat ($urandom_range(1, 3)) send_item(ACT_APPEND, random_handle(), random_num());
        send_item(ACT_POP, random_handle(), base_now + 63'($urandom_range(20, 63)));
        if ($urandom_range(0, 1) == 1) send_item(ACT_CLEAR, random_handle(), random_num());
        fills++;
      end else begin
        repeat (30) random_op();
      end
      // let the block run dry once before going on
      if (phase == 5) begin
        in_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
      end
      phase++;
    end

    // drain
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);

    $display("tb: %0d items sent: %0d appends, %0d pops, %0d clears, %0d base resets",
             sent_total, sent_by_action[ACT_APPEND], sent_by_action[ACT_POP],
             sent_by_action[ACT_CLEAR], sent_by_action[ACT_RESET]);
    $display("tb: %0d result items checked, %0d full-queue overflow runs, %0d mismatches",
             results_seen, fills, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/icq_pkg.sv
rtl/icq_front.sv
rtl/icq_cmdq.sv
rtl/icq_back.sv
rtl/indexed_completion_queue.sv
rtl/icq_checker.sv
verif/icq_result_checker.sv
verif/indexed_completion_queue_test.sv
